// ===== sv/lbc_pkg.sv =====
package lbc_pkg;

  localparam int COORD_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int U_W        = FRAC_W + 1;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PQ_W       = COORD_W + 2;
  localparam int MAG_W      = COORD_W;
  localparam int PROD_W     = MAG_W + U_W;
  localparam int DIV_STEPS  = FRAC_W + 1;
  localparam int NUM_EDGES  = 4;
  localparam int NUM_COORDS = 4;
  localparam int NUM_STAGES = DIV_STEPS + 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_X_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_X_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_B = 2'd3;

  localparam logic [U_W-1:0] U_ONE = U_W'(1) << FRAC_W;

  typedef struct packed {
    logic             used;
    logic             entry;
    logic             one;
    logic             rej;
    logic [MAG_W-1:0] n;
    logic [MAG_W-1:0] d;
  } clip_edge_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
  } seg_base_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } clip_res_t;

endpackage

// ===== sv/lbc_if.sv =====
interface lbc_seg_if;
  logic                              valid;
  logic                              ready;
  logic signed [lbc_pkg::COORD_W-1:0] start_x;
  logic signed [lbc_pkg::COORD_W-1:0] start_y;
  logic signed [lbc_pkg::COORD_W-1:0] end_x;
  logic signed [lbc_pkg::COORD_W-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lbc_clip_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic signed [lbc_pkg::COORD_W-1:0] out_start_x;
  logic signed [lbc_pkg::COORD_W-1:0] out_start_y;
  logic signed [lbc_pkg::COORD_W-1:0] out_end_x;
  logic signed [lbc_pkg::COORD_W-1:0] out_end_y;
  modport source (output valid, accepted, out_start_x, out_start_y, out_end_x, out_end_y,
                  input ready);
  modport sink (input valid, accepted, out_start_x, out_start_y, out_end_x, out_end_y,
                output ready);
endinterface

// ===== sv/lbc_setup.sv =====
module lbc_setup (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [lbc_pkg::COORD_W-1:0] win_xa,
  input  logic signed [lbc_pkg::COORD_W-1:0] win_xb,
  input  logic signed [lbc_pkg::COORD_W-1:0] win_ya,
  input  logic signed [lbc_pkg::COORD_W-1:0] win_yb,
  input  logic signed [lbc_pkg::COORD_W-1:0] x0,
  input  logic signed [lbc_pkg::COORD_W-1:0] y0,
  input  logic signed [lbc_pkg::COORD_W-1:0] x1,
  input  logic signed [lbc_pkg::COORD_W-1:0] y1,
  output lbc_pkg::clip_edge_t                edges [lbc_pkg::NUM_EDGES],
  output lbc_pkg::seg_base_t                 base
);

  function automatic lbc_pkg::clip_edge_t classify(
    input logic signed [lbc_pkg::PQ_W-1:0] p,
    input logic signed [lbc_pkg::PQ_W-1:0] q
  );
    lbc_pkg::clip_edge_t e;
    logic signed [lbc_pkg::PQ_W-1:0] n;
    logic signed [lbc_pkg::PQ_W-1:0] d;
    e = '0;
    n = q;
    d = p;
    if (p < 0) begin
      n = -q;
      d = -p;
      e.entry = 1'b1;
      e.rej   = n > d;
      e.used  = (n > 0) && !(n > d);
      e.one   = n == d;
    end else if (p > 0) begin
      e.rej  = n < 0;
      e.used = !(n < 0) && (n < d);
    end else begin
      e.rej = q < 0;
    end
    e.n = n[lbc_pkg::MAG_W-1:0];
    e.d = d[lbc_pkg::MAG_W-1:0];
    return e;
  endfunction

  logic signed [lbc_pkg::PQ_W-1:0] xl, xr, ylo, yhi, ex0, ey0, ex1, ey1, dxw, dyw;

  always_comb begin
    ex0 = lbc_pkg::PQ_W'(x0);
    ey0 = lbc_pkg::PQ_W'(y0);
    ex1 = lbc_pkg::PQ_W'(x1);
    ey1 = lbc_pkg::PQ_W'(y1);
    xl  = (win_xa < win_xb) ? lbc_pkg::PQ_W'(win_xa) : lbc_pkg::PQ_W'(win_xb);
    xr  = (win_xa < win_xb) ? lbc_pkg::PQ_W'(win_xb) : lbc_pkg::PQ_W'(win_xa);
    ylo = (win_ya < win_yb) ? lbc_pkg::PQ_W'(win_ya) : lbc_pkg::PQ_W'(win_yb);
    yhi = (win_ya < win_yb) ? lbc_pkg::PQ_W'(win_yb) : lbc_pkg::PQ_W'(win_ya);
    dxw = ex1 - ex0;
    dyw = ey1 - ey0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      edges[0] <= classify(-dxw, ex0 - xl);
      edges[1] <= classify(dxw, xr - ex0);
      edges[2] <= classify(-dyw, ey0 - ylo);
      edges[3] <= classify(dyw, yhi - ey0);
      base.x0  <= x0;
      base.y0  <= y0;
      base.dx  <= dxw[lbc_pkg::DIFF_W-1:0];
      base.dy  <= dyw[lbc_pkg::DIFF_W-1:0];
    end
  end

endmodule

// ===== sv/lbc_div.sv =====
module lbc_div (
  input  logic                          clk,
  input  logic [lbc_pkg::DIV_STEPS-1:0] en,
  input  lbc_pkg::clip_edge_t           edges_in [lbc_pkg::NUM_EDGES],
  input  lbc_pkg::seg_base_t            base_in,
  output lbc_pkg::clip_edge_t           edges_out [lbc_pkg::NUM_EDGES],
  output logic [lbc_pkg::U_W-1:0]       quot_out [lbc_pkg::NUM_EDGES],
  output lbc_pkg::seg_base_t            base_out
);

  lbc_pkg::clip_edge_t      edges [lbc_pkg::DIV_STEPS][lbc_pkg::NUM_EDGES];
  logic [lbc_pkg::MAG_W-1:0] rem  [lbc_pkg::DIV_STEPS][lbc_pkg::NUM_EDGES];
  logic [lbc_pkg::U_W-1:0]   quot [lbc_pkg::DIV_STEPS][lbc_pkg::NUM_EDGES];
  lbc_pkg::seg_base_t        base [lbc_pkg::DIV_STEPS];

  // one quotient bit per stage for every edge lane
  for (genvar k = 0; k < lbc_pkg::DIV_STEPS; k++) begin : g_step
    for (genvar e = 0; e < lbc_pkg::NUM_EDGES; e++) begin : g_lane
      logic [lbc_pkg::MAG_W-1:0] rem_prev;
      logic [lbc_pkg::U_W-1:0]   quot_prev;
      logic [lbc_pkg::MAG_W:0]   rem2;
      logic [lbc_pkg::MAG_W:0]   diff;
      logic                      ge;
      lbc_pkg::clip_edge_t       edge_prev;

      if (k == 0) begin : g_first
        assign edge_prev = edges_in[e];
        assign rem_prev  = edges_in[e].n;
        assign quot_prev = '0;
      end else begin : g_next
        assign edge_prev = edges[k-1][e];
        assign rem_prev  = rem[k-1][e];
        assign quot_prev = quot[k-1][e];
      end

      assign rem2 = {rem_prev, 1'b0};
      assign ge   = rem2 >= {1'b0, edge_prev.d};
      assign diff = rem2 - {1'b0, edge_prev.d};

      always_ff @(posedge clk) begin
        if (en[k]) begin
          edges[k][e] <= edge_prev;
          rem[k][e]   <= ge ? diff[lbc_pkg::MAG_W-1:0] : rem2[lbc_pkg::MAG_W-1:0];
          quot[k][e]  <= {quot_prev[lbc_pkg::U_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        base[k] <= (k == 0) ? base_in : base[(k == 0) ? 0 : k-1];
      end
    end
  end

  for (genvar e = 0; e < lbc_pkg::NUM_EDGES; e++) begin : g_out
    assign edges_out[e] = edges[lbc_pkg::DIV_STEPS-1][e];
    assign quot_out[e]  = quot[lbc_pkg::DIV_STEPS-1][e];
  end
  assign base_out = base[lbc_pkg::DIV_STEPS-1];

endmodule

// ===== sv/lbc_interp.sv =====
module lbc_interp (
  input  logic                    clk,
  input  logic [2:0]              en,
  input  lbc_pkg::clip_edge_t     edges [lbc_pkg::NUM_EDGES],
  input  logic [lbc_pkg::U_W-1:0] quot [lbc_pkg::NUM_EDGES],
  input  lbc_pkg::seg_base_t      base_in,
  output lbc_pkg::clip_res_t      res
);

  localparam logic [lbc_pkg::PROD_W:0] HALF = (lbc_pkg::PROD_W+1)'(1) << (lbc_pkg::FRAC_W - 1);

  // combine stage
  logic                    acc_c;
  logic [lbc_pkg::U_W-1:0] entry_c, exit_c;
  logic                    acc_r;
  logic [lbc_pkg::U_W-1:0] entry_r, exit_r;
  lbc_pkg::seg_base_t      base_r;

  always_comb begin
    logic                    rej;
    logic [lbc_pkg::U_W:0]   rounded;
    logic [lbc_pkg::U_W-1:0] c;
    rej     = 1'b0;
    entry_c = '0;
    exit_c  = lbc_pkg::U_ONE;
    for (int e = 0; e < lbc_pkg::NUM_EDGES; e++) begin
      rounded = {1'b0, quot[e]} + (lbc_pkg::U_W+1)'(1);
      c = edges[e].one ? lbc_pkg::U_ONE : rounded[lbc_pkg::U_W:1];
      rej = rej | edges[e].rej;
      if (edges[e].used && edges[e].entry && (c > entry_c)) entry_c = c;
      if (edges[e].used && !edges[e].entry && (c < exit_c)) exit_c = c;
    end
    acc_c = !rej && (entry_c <= exit_c);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      acc_r   <= acc_c;
      entry_r <= entry_c;
      exit_r  <= exit_c;
      base_r  <= base_in;
    end
  end

  // multiply stage: start x, start y, end x, end y
  logic signed [lbc_pkg::DIFF_W-1:0]  delta [lbc_pkg::NUM_COORDS];
  logic signed [lbc_pkg::COORD_W-1:0] org   [lbc_pkg::NUM_COORDS];
  logic [lbc_pkg::U_W-1:0]            uval  [lbc_pkg::NUM_COORDS];
  logic [lbc_pkg::PROD_W-1:0]         prod  [lbc_pkg::NUM_COORDS];
  logic                               neg   [lbc_pkg::NUM_COORDS];
  logic signed [lbc_pkg::COORD_W-1:0] org_r [lbc_pkg::NUM_COORDS];
  logic                               acc_m;

  assign delta[0] = base_r.dx;
  assign delta[1] = base_r.dy;
  assign delta[2] = base_r.dx;
  assign delta[3] = base_r.dy;
  assign org[0]   = base_r.x0;
  assign org[1]   = base_r.y0;
  assign org[2]   = base_r.x0;
  assign org[3]   = base_r.y0;
  assign uval[0]  = entry_r;
  assign uval[1]  = entry_r;
  assign uval[2]  = exit_r;
  assign uval[3]  = exit_r;

  for (genvar i = 0; i < lbc_pkg::NUM_COORDS; i++) begin : g_mul
    logic signed [lbc_pkg::DIFF_W-1:0] mag;
    assign mag = delta[i] < 0 ? -delta[i] : delta[i];
    always_ff @(posedge clk) begin
      if (en[1]) begin
        prod[i]  <= lbc_pkg::MAG_W'(mag) * uval[i];
        neg[i]   <= delta[i] < 0;
        org_r[i] <= org[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) acc_m <= acc_r;
  end

  // round, add to the start point, zero a rejected segment
  logic signed [lbc_pkg::COORD_W-1:0] pt [lbc_pkg::NUM_COORDS];

  for (genvar i = 0; i < lbc_pkg::NUM_COORDS; i++) begin : g_add
    logic [lbc_pkg::PROD_W:0] sum;
    logic [lbc_pkg::COORD_W-1:0] off;
    assign sum   = {1'b0, prod[i]} + HALF;
    assign off   = sum[lbc_pkg::FRAC_W +: lbc_pkg::COORD_W];
    assign pt[i] = neg[i] ? org_r[i] - $signed(off) : org_r[i] + $signed(off);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res.accepted <= acc_m;
      res.sx       <= acc_m ? pt[0] : '0;
      res.sy       <= acc_m ? pt[1] : '0;
      res.ex       <= acc_m ? pt[2] : '0;
      res.ey       <= acc_m ? pt[3] : '0;
    end
  end

  a_entry_le_exit: assert property (@(posedge clk) acc_r |-> entry_r <= exit_r)
    else $error("accepted segment with entry above exit");
  a_u_range: assert property (@(posedge clk) acc_r |-> exit_r <= lbc_pkg::U_ONE)
    else $error("exit parameter above one");

endmodule

// ===== sv/line_segment_rect_clipper_unit.sv =====
// Channel   Role    Payload
// seg_in    sink    start_x, start_y, end_x, end_y
// seg_out   source  accepted, out_start_x, out_start_y, out_end_x, out_end_y
// cfg       write   cfg_we, cfg_index, cfg_data (window edges, index 0..3)
//
// One segment per cycle, unless the output stalls, through 21 register stages:
// one setup stage, 17 stages of the restoring divider (one quotient bit each),
// then combine, multiply and round stages. Each stage holds its own valid bit;
// a stage moves when it is empty or the next one moves, so bubbles close under
// a stall.
// Synchronous reset clears the valid bits and loads the default window.
module line_segment_rect_clipper_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lbc_pkg::COORD_W-1:0]     cfg_data,
  lbc_seg_if.sink                         seg_in,
  lbc_clip_if.source                      seg_out
);

  localparam int NS = lbc_pkg::NUM_STAGES;
  localparam int DS = lbc_pkg::DIV_STEPS;

  logic signed [lbc_pkg::COORD_W-1:0] win_xa, win_xb, win_ya, win_yb;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_xa <= lbc_pkg::COORD_W'(0);
      win_xb <= lbc_pkg::COORD_W'(1023);
      win_ya <= lbc_pkg::COORD_W'(0);
      win_yb <= lbc_pkg::COORD_W'(1023);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbc_pkg::REG_WIN_X_A: win_xa <= cfg_data;
        lbc_pkg::REG_WIN_X_B: win_xb <= cfg_data;
        lbc_pkg::REG_WIN_Y_A: win_ya <= cfg_data;
        lbc_pkg::REG_WIN_Y_B: win_yb <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || seg_out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) vld[i] <= (i == 0) ? seg_in.valid : vld[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign seg_in.ready = en[0];

  lbc_pkg::clip_edge_t     edges_s [lbc_pkg::NUM_EDGES];
  lbc_pkg::seg_base_t      base_s;
  lbc_pkg::clip_edge_t     edges_d [lbc_pkg::NUM_EDGES];
  logic [lbc_pkg::U_W-1:0] quot_d  [lbc_pkg::NUM_EDGES];
  lbc_pkg::seg_base_t      base_d;
  lbc_pkg::clip_res_t      res;

  lbc_setup u_setup (
    .clk    (clk),
    .en     (en[0]),
    .win_xa (win_xa),
    .win_xb (win_xb),
    .win_ya (win_ya),
    .win_yb (win_yb),
    .x0     (seg_in.start_x),
    .y0     (seg_in.start_y),
    .x1     (seg_in.end_x),
    .y1     (seg_in.end_y),
    .edges  (edges_s),
    .base   (base_s)
  );

  lbc_div u_div (
    .clk       (clk),
    .en        (en[DS:1]),
    .edges_in  (edges_s),
    .base_in   (base_s),
    .edges_out (edges_d),
    .quot_out  (quot_d),
    .base_out  (base_d)
  );

  lbc_interp u_interp (
    .clk     (clk),
    .en      (en[NS-1:NS-3]),
    .edges   (edges_d),
    .quot    (quot_d),
    .base_in (base_d),
    .res     (res)
  );

  assign seg_out.valid       = vld[NS-1];
  assign seg_out.accepted    = res.accepted;
  assign seg_out.out_start_x = res.sx;
  assign seg_out.out_start_y = res.sy;
  assign seg_out.out_end_x   = res.ex;
  assign seg_out.out_end_y   = res.ey;

  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
      seg_out.valid && !seg_out.accepted |->
      seg_out.out_start_x == '0 && seg_out.out_start_y == '0 &&
      seg_out.out_end_x == '0 && seg_out.out_end_y == '0)
    else $error("rejected segment with nonzero coordinates");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
      vld[NS-1] && !seg_out.ready |=> vld[NS-1])
    else $error("stalled result dropped");

endmodule
